### src/eida_pkg.sv
// ----------------------------------------------------------------------------
// eida_pkg
// Shared types, constants and helpers for the identifier allocator.
// ----------------------------------------------------------------------------
package eida_pkg;

  localparam int MAX_IDS  = 1024;
  localparam int SIG_BITS = 32;
  localparam int ID_W     = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CNT_W    = $clog2(MAX_IDS + 1);
  localparam int ENT_W    = 16;
  localparam int COMP_W   = 5;
  localparam int EOUT_W   = 10;
  localparam int SOUT_W   = 32;
  localparam int LIVE_W   = 11;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_SET     = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NONE_LIVE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_EXEC  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    op_t               op;
    logic [ENT_W-1:0]  entity_in;
    logic [COMP_W-1:0] component;
  } in_t;

  typedef struct packed {
    logic [EOUT_W-1:0] entity_out;
    logic [SOUT_W-1:0] signature;
    logic              has_component;
    logic [LIVE_W-1:0] live_count;
    status_t           status;
  } out_t;

  typedef struct packed {
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    logic            wr_en;
    logic [ID_W-1:0] wr_addr;
    logic [ID_W-1:0] wr_data;
  } fl_req_t;

  typedef struct packed {
    logic                rd_en;
    logic [ID_W-1:0]     rd_addr;
    logic                wr_en;
    logic [ID_W-1:0]     wr_addr;
    logic [SIG_BITS-1:0] wr_data;
  } sig_req_t;

  function automatic logic [SIG_BITS-1:0] comp_mask(logic [COMP_W-1:0] c);
    logic [SIG_BITS-1:0] m;
    m = '0;
    if (int'(c) < SIG_BITS) begin
      m = SIG_BITS'(1) << c;
    end
    return m;
  endfunction

  function automatic logic [SOUT_W-1:0] sig_to_out(logic [SIG_BITS-1:0] s);
    logic [SIG_BITS+SOUT_W-1:0] w;
    w = {{SOUT_W{1'b0}}, s};
    return w[SOUT_W-1:0];
  endfunction

  function automatic logic [EOUT_W-1:0] id_to_out(logic [ID_W-1:0] id);
    logic [ID_W+EOUT_W-1:0] w;
    w = {{EOUT_W{1'b0}}, id};
    return w[EOUT_W-1:0];
  endfunction

  function automatic logic [LIVE_W-1:0] live_to_out(logic [CNT_W-1:0] n);
    logic [CNT_W+LIVE_W-1:0] w;
    w = {{LIVE_W{1'b0}}, n};
    return w[LIVE_W-1:0];
  endfunction

endpackage

### src/eida_free_list.sv
// ----------------------------------------------------------------------------
// eida_free_list
// Free-list memory; slots not yet written since reset read as their index.
// ----------------------------------------------------------------------------
module eida_free_list (
  input  logic                  clk,
  input  logic                  rst_n,
  input  eida_pkg::fl_req_t     req,
  output logic [eida_pkg::ID_W-1:0] rd_data
);

  logic [eida_pkg::ID_W-1:0]  mem [eida_pkg::MAX_IDS];
  logic [eida_pkg::ID_W-1:0]  rd_q_r;
  logic [eida_pkg::ID_W-1:0]  rd_addr_r;
  logic                       hit_r;
  logic [eida_pkg::CNT_W-1:0] fill_r;
  logic [eida_pkg::CNT_W-1:0] fill_nxt;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r    <= mem[req.rd_addr];
      rd_addr_r <= req.rd_addr;
      hit_r     <= (eida_pkg::CNT_W'(req.rd_addr) < fill_r);
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (req.wr_en && (fill_r != eida_pkg::CNT_W'(eida_pkg::MAX_IDS))) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign rd_data = hit_r ? rd_q_r : rd_addr_r;

endmodule

### src/eida_sig_store.sv
// ----------------------------------------------------------------------------
// eida_sig_store
// Signature memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module eida_sig_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  eida_pkg::sig_req_t            req,
  output logic [eida_pkg::SIG_BITS-1:0] rd_data,
  output logic                          ready
);

  logic [eida_pkg::SIG_BITS-1:0] mem [eida_pkg::MAX_IDS];
  logic [eida_pkg::SIG_BITS-1:0] rd_q_r;
  logic [eida_pkg::CNT_W-1:0]    clr_cnt_r;
  logic [eida_pkg::CNT_W-1:0]    clr_cnt_nxt;
  logic                          clr_r;
  logic                          clr_nxt;
  logic                          wr_en;
  logic [eida_pkg::ID_W-1:0]     wr_addr;
  logic [eida_pkg::SIG_BITS-1:0] wr_data;

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    clr_nxt     = clr_r;
    wr_en       = req.wr_en;
    wr_addr     = req.wr_addr;
    wr_data     = req.wr_data;
    if (clr_r) begin
      wr_en       = 1'b1;
      wr_addr     = clr_cnt_r[eida_pkg::ID_W-1:0];
      wr_data     = '0;
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == eida_pkg::CNT_W'(eida_pkg::MAX_IDS - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_q_r;
  assign ready   = !clr_r;

endmodule

### src/eida_ctrl.sv
// ----------------------------------------------------------------------------
// eida_ctrl
// Request sequencer: list pointers, live count, read-modify-write of memories.
// ----------------------------------------------------------------------------
module eida_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  eida_pkg::in_t                 in_req,
  output logic                          busy,
  input  logic                          mem_ready,
  output eida_pkg::fl_req_t             fl_req,
  input  logic [eida_pkg::ID_W-1:0]     fl_rd_data,
  output eida_pkg::sig_req_t            sig_req,
  input  logic [eida_pkg::SIG_BITS-1:0] sig_rd_data,
  output logic                          out_valid,
  output eida_pkg::out_t                out_res
);

  localparam logic [eida_pkg::ID_W-1:0]  LAST_ID = eida_pkg::ID_W'(eida_pkg::MAX_IDS - 1);
  localparam logic [eida_pkg::CNT_W-1:0] FULL    = eida_pkg::CNT_W'(eida_pkg::MAX_IDS);
  localparam logic [eida_pkg::ENT_W:0]   ENT_LIM = (eida_pkg::ENT_W + 1)'(eida_pkg::MAX_IDS);

  eida_pkg::ctrl_state_t         state_r, state_nxt;
  eida_pkg::in_t                 req_r, req_nxt;
  logic [eida_pkg::ID_W-1:0]     head_r, head_nxt;
  logic [eida_pkg::ID_W-1:0]     tail_r, tail_nxt;
  logic [eida_pkg::CNT_W-1:0]    live_r, live_nxt;
  logic [eida_pkg::ID_W-1:0]     id_r, id_nxt;
  logic                          out_valid_r, out_valid_nxt;
  eida_pkg::out_t                out_res_r, out_res_nxt;
  logic                          accept;
  logic                          ok;
  logic [eida_pkg::SIG_BITS-1:0] mask;
  logic [eida_pkg::SIG_BITS-1:0] sig;
  logic [eida_pkg::ID_W-1:0]     ent_idx;

  assign busy    = (state_r != eida_pkg::S_IDLE) || !mem_ready;
  assign accept  = start && !busy;
  assign mask    = eida_pkg::comp_mask(req_r.component);
  assign ent_idx = req_r.entity_in[eida_pkg::ID_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    live_nxt      = live_r;
    id_nxt        = id_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    fl_req        = '0;
    sig_req       = '0;
    ok            = 1'b0;
    sig           = '0;
    case (state_r)
      eida_pkg::S_IDLE: begin
        if (accept) begin
          req_nxt         = in_req;
          fl_req.rd_en    = 1'b1;
          fl_req.rd_addr  = head_r;
          sig_req.rd_en   = 1'b1;
          sig_req.rd_addr = in_req.entity_in[eida_pkg::ID_W-1:0];
          state_nxt = (in_req.op == eida_pkg::OP_CREATE) ? eida_pkg::S_FETCH
                                                         : eida_pkg::S_EXEC;
        end
      end
      eida_pkg::S_FETCH: begin
        id_nxt          = fl_rd_data;
        sig_req.rd_en   = 1'b1;
        sig_req.rd_addr = fl_rd_data;
        state_nxt       = eida_pkg::S_EXEC;
      end
      eida_pkg::S_EXEC: begin
        out_valid_nxt          = 1'b1;
        out_res_nxt.entity_out = req_r.entity_in[eida_pkg::EOUT_W-1:0];
        out_res_nxt.status     = eida_pkg::ST_OK;
        if (req_r.op == eida_pkg::OP_CREATE) begin
          if (live_r == FULL) begin
            out_res_nxt.status     = eida_pkg::ST_NO_FREE;
            out_res_nxt.entity_out = '0;
          end else begin
            ok                     = 1'b1;
            sig                    = sig_rd_data;
            out_res_nxt.entity_out = eida_pkg::id_to_out(id_r);
            head_nxt               = (head_r == LAST_ID) ? '0 : head_r + 1'b1;
            live_nxt               = live_r + 1'b1;
          end
        end else if ({1'b0, req_r.entity_in} >= ENT_LIM) begin
          out_res_nxt.status = eida_pkg::ST_RANGE;
        end else if (req_r.op == eida_pkg::OP_DESTROY) begin
          if (live_r == '0) begin
            out_res_nxt.status = eida_pkg::ST_NONE_LIVE;
          end else begin
            ok              = 1'b1;
            sig_req.wr_en   = 1'b1;
            sig_req.wr_addr = ent_idx;
            sig_req.wr_data = '0;
            fl_req.wr_en    = 1'b1;
            fl_req.wr_addr  = tail_r;
            fl_req.wr_data  = ent_idx;
            tail_nxt        = (tail_r == LAST_ID) ? '0 : tail_r + 1'b1;
            live_nxt        = live_r - 1'b1;
          end
        end else if (req_r.op == eida_pkg::OP_SET) begin
          ok              = 1'b1;
          sig             = sig_rd_data | mask;
          sig_req.wr_en   = 1'b1;
          sig_req.wr_addr = ent_idx;
          sig_req.wr_data = sig;
        end else begin
          ok  = 1'b1;
          sig = sig_rd_data;
        end
        out_res_nxt.signature     = eida_pkg::sig_to_out(sig);
        out_res_nxt.has_component = ok && ((sig & mask) != '0);
        out_res_nxt.live_count    = eida_pkg::live_to_out(live_nxt);
        state_nxt                 = eida_pkg::S_IDLE;
      end
      default: begin
        state_nxt = eida_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= eida_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    id_r      <= id_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTH
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= FULL)
    else $error("live count above capacity");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == eida_pkg::S_EXEC)
    else $error("result strobe without execute cycle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != eida_pkg::S_IDLE)
    else $error("accepted request did not start");

  a_live_changes_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r != $past(live_r)) |-> $past(state_r) == eida_pkg::S_EXEC)
    else $error("live count moved outside execute");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !mem_ready |-> !accept)
    else $error("request taken during clearing sweep");
`endif

endmodule

### src/entity_id_allocator_with_signatures_top.sv
// ----------------------------------------------------------------------------
// entity_id_allocator_with_signatures_top
// Identifier allocator with a FIFO free list and per-identifier signatures.
// ----------------------------------------------------------------------------
// Request channel: drive in_req and raise start; the transfer happens at a
// rising edge with start high and busy low. Ops: create, destroy, set a
// component bit, read signature and test a bit.
// Result channel: out_valid is high for one cycle with out_res; the
// receiver takes it at the end of that cycle and cannot stall it.
// Sequence: a create does a free-list read, then a signature read at the
// fetched identifier, then write-back; other ops read the signature at
// transfer and go straight to write-back. busy drops in the strobe cycle,
// so a new request is taken only once the previous result is out; both
// memories have registered reads, and a create's two reads are in series.
// Reset: rst_n low clears pointers and the live count, then a sweep
// zeroes every entry of the signature memory with busy held high.
// ----------------------------------------------------------------------------
module entity_id_allocator_with_signatures_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  eida_pkg::in_t  in_req,
  output logic           out_valid,
  output eida_pkg::out_t out_res
);

  eida_pkg::fl_req_t             fl_req;
  eida_pkg::sig_req_t            sig_req;
  logic [eida_pkg::ID_W-1:0]     fl_rd_data;
  logic [eida_pkg::SIG_BITS-1:0] sig_rd_data;
  logic                          mem_ready;

  eida_free_list u_free_list (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (fl_req),
    .rd_data (fl_rd_data)
  );

  eida_sig_store u_sig_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sig_req),
    .rd_data (sig_rd_data),
    .ready   (mem_ready)
  );

  eida_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req      (in_req),
    .busy        (busy),
    .mem_ready   (mem_ready),
    .fl_req      (fl_req),
    .fl_rd_data  (fl_rd_data),
    .sig_req     (sig_req),
    .sig_rd_data (sig_rd_data),
    .out_valid   (out_valid),
    .out_res     (out_res)
  );

endmodule
